### rtl/sbr_pkg.sv
`timescale 1ns / 1ps
// Shared types for the stream byte reassembler.
// No dependencies; used by every module of the block.
package sbr_pkg;

	typedef enum logic [1:0] {
		K_BYTE  = 2'd0,
		K_MARK  = 2'd1,
		K_DRAIN = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] idx;
		logic [7:0]  data;
		logic        seg_end;
		logic        last;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} head_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STORE,
		ST_DRAIN,
		ST_ADV_RD,
		ST_ADV_CHK,
		ST_DONE
	} state_t;

	localparam int OP_W = 2;

endpackage

### rtl/stream_byte_reassembler.sv
`timescale 1ns / 1ps
// Stream byte reassembler, top level. The back end works on one transaction at a
// time, so it starts no new transaction until the last has been written to its
// result register. After reset a clearing pass wipes the valid bitmap; inputs
// are held off until it ends. Depends on sbr_pkg, sbr_front, sbr_back.
module stream_byte_reassembler #(
	parameter int CAPACITY = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // stream_index[63:0], data_byte[71:64]
	input  logic [2:0]  s_tuser,   // op[1:0], last_substring[2]
	input  logic        s_tlast,   // segment_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte[7:0], pending_count[20:8], zero
	output logic [1:0]  m_tuser,   // out_valid[0], stream_closed[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data   // window_size
);
	import sbr_pkg::*;

	logic [12:0] window_q;
	head_t       head;
	logic        pop;
	logic        en;
	logic        r_ov;
	logic [7:0]  r_byte;
	logic [12:0] r_pend;
	logic        r_closed;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	sbr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.op             (s_tuser[1:0]),
		.stream_index   (s_tdata[63:0]),
		.data_byte      (s_tdata[71:64]),
		.segment_end    (s_tlast),
		.last_substring (s_tuser[2]),
		.head           (head),
		.pop            (pop)
	);

	sbr_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.window_size     (window_q),
		.head            (head),
		.pop             (pop),
		.ready_for_items (en),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.res_out_valid   (r_ov),
		.res_byte        (r_byte),
		.res_pending     (r_pend),
		.res_closed      (r_closed)
	);

	assign m_tdata = {3'b000, r_pend, r_byte};
	assign m_tuser = {r_closed, r_ov};

endmodule

### rtl/sbr_front.sv
`timescale 1ns / 1ps
// Front end: takes input transactions, decodes the operation and holds them
// in a two-entry queue for the back end. Depends on sbr_pkg.
module sbr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [sbr_pkg::OP_W-1:0]  op,
	input  logic [63:0]               stream_index,
	input  logic [7:0]                data_byte,
	input  logic                      segment_end,
	input  logic                      last_substring,
	output sbr_pkg::head_t            head,
	input  logic                      pop
);
	import sbr_pkg::*;

	item_t       ent_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	item_t       dec;
	logic        push;
	logic        do_pop;

	always_comb begin
		dec.kind    = kind_t'(op);
		dec.idx     = stream_index;
		dec.data    = data_byte;
		dec.seg_end = segment_end;
		dec.last    = last_substring;
	end

	assign in_ready  = en && (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign do_pop    = pop && (cnt_q != 2'd0);
	assign head.vld  = (cnt_q != 2'd0);
	assign head.item = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

### rtl/sbr_back.sv
`timescale 1ns / 1ps
// Back end: byte ring, valid bitmap, window and end-of-stream tracking and the
// in-order scan, which reads and then checks one bitmap entry at a time. Depends on sbr_pkg.
module sbr_back #(
	parameter int CAPACITY = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [12:0]          window_size,
	input  sbr_pkg::head_t       head,
	output logic                 pop,
	output logic                 ready_for_items,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 res_out_valid,
	output logic [7:0]           res_byte,
	output logic [12:0]          res_pending,
	output logic                 res_closed
);
	import sbr_pkg::*;

	localparam int SW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int NW  = (CW > 13) ? CW : 13;
	localparam logic [SW:0]   CAP_S  = (SW + 1)'(CAPACITY);
	localparam logic [SW-1:0] LAST_S = SW'(CAPACITY - 1);
	localparam logic [NW-1:0] CAP_N  = NW'(CAPACITY);
	localparam logic [63:0]   CAP_64 = 64'(CAPACITY);

	logic [7:0]    ring_mem [CAPACITY];
	logic          vmap_mem [CAPACITY];

	state_t        state_q, state_d;
	logic [63:0]   inorder_q, drain_q, end_pos_q;
	logic [SW-1:0] in_slot_q, dr_slot_q, clr_q, slot_q;
	logic [NW-1:0] pending_q;
	logic          end_known_q, closed_q;
	logic [7:0]    data_q, ring_rd_q;
	logic          vmap_rd_q;
	kind_t         kind_q;
	logic          drained_q;
	logic          out_valid_q, out_ov_q, out_closed_q;
	logic [7:0]    out_byte_q;
	logic [12:0]   out_pend_q;

	item_t         it;
	logic [63:0]   diff, next_end;
	logic [NW-1:0] win_n, effw;
	logic          in_win, end_new, eff_known, beyond;
	logic [SW:0]   slot_sum;
	logic [SW-1:0] pos_slot;
	logic          can_drain, room_scan, out_free, closing;

	// Memory strobes.
	logic          v_we, v_wd, v_re, r_we, r_re;
	logic [SW-1:0] v_addr;

	assign it        = head.item;
	assign diff      = it.idx - drain_q;
	assign win_n     = NW'(window_size);
	assign effw      = (win_n > CAP_N) ? CAP_N : win_n;
	assign in_win    = (it.idx >= drain_q) && (diff < 64'(effw));
	assign slot_sum  = {1'b0, dr_slot_q} + {1'b0, diff[SW-1:0]};
	assign pos_slot  = (slot_sum >= CAP_S) ? SW'(slot_sum - CAP_S) : slot_sum[SW-1:0];
	assign end_new   = it.last && it.seg_end && !end_known_q;
	assign next_end  = it.idx + 64'd1;
	assign eff_known = end_known_q || end_new;
	assign beyond    = eff_known && (it.idx >= (end_new ? next_end : end_pos_q));
	assign can_drain = drain_q < inorder_q;
	assign room_scan = (inorder_q - drain_q) < CAP_64;
	assign out_free  = !out_valid_q || res_ready;
	assign closing   = ((kind_q == K_DRAIN) ||
		(((kind_q == K_BYTE) || (kind_q == K_MARK)) && !closed_q)) &&
		end_known_q && (inorder_q >= end_pos_q);

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == LAST_S) ? '0 : s + SW'(1);
	endfunction

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_S) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head.vld) begin
					state_d = ST_DONE;
					case (it.kind)
						K_BYTE: begin
							if (!closed_q && in_win && !beyond) begin
								state_d = ST_STORE;
							end
						end
						K_DRAIN: begin
							if (can_drain) begin
								state_d = ST_DRAIN;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_STORE:   state_d = vmap_rd_q ? ST_DONE : ST_ADV_RD;
			ST_DRAIN:   state_d = ST_ADV_RD;
			ST_ADV_RD:  state_d = room_scan ? ST_ADV_CHK : ST_DONE;
			ST_ADV_CHK: state_d = vmap_rd_q ? ST_ADV_RD : ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		pop    = 1'b0;
		v_we   = 1'b0;
		v_wd   = 1'b0;
		v_re   = 1'b0;
		r_we   = 1'b0;
		r_re   = 1'b0;
		v_addr = in_slot_q;
		case (state_q)
			ST_CLEAR: begin
				v_we   = 1'b1;
				v_addr = clr_q;
			end
			ST_IDLE: begin
				pop = head.vld;
				if (head.vld && it.kind == K_BYTE) begin
					v_re   = 1'b1;
					v_addr = pos_slot;
				end
				r_re = head.vld && (it.kind == K_DRAIN);
			end
			ST_STORE: begin
				v_we   = !vmap_rd_q;
				v_wd   = 1'b1;
				r_we   = !vmap_rd_q;
				v_addr = slot_q;
			end
			ST_DRAIN: begin
				v_we   = 1'b1;
				v_addr = dr_slot_q;
			end
			ST_ADV_RD: begin
				v_re = 1'b1;
			end
			default: v_addr = in_slot_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			vmap_mem[v_addr] <= v_wd;
		end
		if (v_re) begin
			vmap_rd_q <= vmap_mem[v_addr];
		end
		if (r_we) begin
			ring_mem[slot_q] <= data_q;
		end
		if (r_re) begin
			ring_rd_q <= ring_mem[dr_slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			inorder_q    <= '0;
			drain_q      <= '0;
			in_slot_q    <= '0;
			dr_slot_q    <= '0;
			pending_q    <= '0;
			end_known_q  <= 1'b0;
			end_pos_q    <= '0;
			closed_q     <= 1'b0;
			kind_q       <= K_NONE;
			drained_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_ov_q     <= 1'b0;
			out_byte_q   <= '0;
			out_pend_q   <= '0;
			out_closed_q <= 1'b0;
			slot_q       <= '0;
			data_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + SW'(1);
				ST_IDLE: begin
					if (head.vld) begin
						kind_q    <= it.kind;
						drained_q <= 1'b0;
						slot_q    <= pos_slot;
						data_q    <= it.data;
						if (!closed_q && in_win && it.kind == K_BYTE && end_new) begin
							end_known_q <= 1'b1;
							end_pos_q   <= next_end;
						end
						if (!closed_q && in_win && it.kind == K_MARK && it.last &&
							!end_known_q) begin
							end_known_q <= 1'b1;
							end_pos_q   <= it.idx;
						end
					end
				end
				ST_STORE: begin
					if (!vmap_rd_q) begin
						pending_q <= pending_q + NW'(1);
					end
				end
				ST_DRAIN: begin
					drained_q <= 1'b1;
					drain_q   <= drain_q + 64'd1;
					dr_slot_q <= slot_inc(dr_slot_q);
				end
				ST_ADV_CHK: begin
					if (vmap_rd_q) begin
						if (pending_q != '0) begin
							pending_q <= pending_q - NW'(1);
						end
						inorder_q <= inorder_q + 64'd1;
						in_slot_q <= slot_inc(in_slot_q);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (closing) begin
							closed_q <= 1'b1;
						end
						out_valid_q  <= 1'b1;
						out_ov_q     <= drained_q;
						out_byte_q   <= drained_q ? ring_rd_q : 8'd0;
						out_pend_q   <= pending_q[12:0];
						out_closed_q <= closed_q || closing;
					end
				end
				default: clr_q <= clr_q;
			endcase
		end
	end

	assign ready_for_items = (state_q != ST_CLEAR);
	assign res_valid       = out_valid_q;
	assign res_out_valid   = out_ov_q;
	assign res_byte        = out_byte_q;
	assign res_pending     = out_pend_q;
	assign res_closed      = out_closed_q;

endmodule

### verif/stream_byte_reassembler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for stream_byte_reassembler: a clocked driver and
// monitor around the block, with a byte-level window model as predictor.
// Depends on sbr_pkg and the stream_byte_reassembler RTL.
module stream_byte_reassembler_test;
	import sbr_pkg::*;

	localparam int RING = 4096;

	typedef struct {
		kind_t       kind;
		logic [63:0] idx;
		logic [7:0]  data;
		logic        seg_end;
		logic        last;
	} seg_item_t;

	typedef struct {
		logic        got_byte;
		logic [7:0]  byte_val;
		logic [12:0] pending;
		logic        closed;
	} status_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] cfg_data;

	stream_byte_reassembler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Model of the window.
	logic [7:0]      ring_bytes [RING];
	bit              held [RING];
	longint unsigned assembled_to;
	longint unsigned drained_to;
	longint unsigned stream_end;
	bit              end_seen;
	bit              is_closed;
	int              pending_q;
	int              window_len;

	seg_item_t to_send[$];
	status_t   status_due[$];
	seg_item_t cur;
	int        idle_mode;
	logic      hold_rx;
	bit        hold_go;
	int        mismatches;
	int        results_seen;
	int        bytes_out;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("stream_byte_reassembler_test: errors");
		$finish;
	end

	function automatic bit in_window(longint unsigned p);
		longint unsigned w;
		w = (window_len > RING) ? RING : window_len;
		return p >= drained_to && (p - drained_to) < w;
	endfunction

	function automatic void advance_assembled();
		while ((assembled_to - drained_to) < RING && held[assembled_to % RING]) begin
			if (pending_q > 0)
				pending_q--;
			assembled_to++;
		end
	endfunction

	function automatic status_t reassemble(seg_item_t it);
		status_t r;
		int s;
		r.got_byte = 1'b0;
		r.byte_val = 8'd0;
		if (it.kind == K_BYTE && !is_closed) begin
			if (in_window(it.idx)) begin
				if (it.last && it.seg_end && !end_seen) begin
					end_seen = 1;
					stream_end = it.idx + 64'd1;
				end
				s = it.idx % RING;
				if (!(end_seen && it.idx >= stream_end) && !held[s]) begin
					ring_bytes[s] = it.data;
					held[s] = 1;
					pending_q++;
					advance_assembled();
				end
			end
		end else if (it.kind == K_MARK && !is_closed) begin
			if (it.last && !end_seen && in_window(it.idx)) begin
				end_seen = 1;
				stream_end = it.idx;
			end
		end else if (it.kind == K_DRAIN) begin
			if (drained_to < assembled_to) begin
				s = drained_to % RING;
				r.got_byte = 1'b1;
				r.byte_val = ring_bytes[s];
				held[s] = 0;
				drained_to++;
				advance_assembled();
			end
		end
		if (it.kind != K_NONE && end_seen && assembled_to >= stream_end)
			is_closed = 1;
		r.pending = pending_q[12:0];
		r.closed = is_closed;
		return r;
	endfunction

	function automatic bit idles(bit sender);
		int pct;
		pct = 0;
		if (idle_mode == 0)
			pct = sender ? 26 : 68;
		else if (idle_mode == 1)
			pct = sender ? 68 : 26;
		return $urandom_range(0, 99) < pct;
	endfunction

	// Driver: the item on the bus is predicted at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				status_due.push_back(reassemble(cur));
			if (!s_tvalid || s_tready) begin
				if (to_send.size() > 0 && !idles(1)) begin
					cur = to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur.data, cur.idx};
					s_tuser <= {cur.last, cur.kind};
					s_tlast <= cur.seg_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		status_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (status_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: tdata %h tuser %b",
							m_tdata, m_tuser);
				end else begin
					e = status_due.pop_front();
					if (e.got_byte)
						bytes_out++;
					if (m_tuser[0] !== e.got_byte || m_tdata[7:0] !== e.byte_val ||
					    m_tdata[20:8] !== e.pending || m_tuser[1] !== e.closed) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected valid %b byte %h pending %0d ",
								"closed %b, got valid %b byte %h pending %0d closed %b"},
								e.got_byte, e.byte_val, e.pending, e.closed,
								m_tuser[0], m_tdata[7:0], m_tdata[20:8], m_tuser[1]);
					end
				end
			end
			m_tready <= !hold_rx && !idles(0);
		end
	end

	// Long receiver hold-off so that the block backs up into its input.
	initial begin
		hold_rx = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (400) @(posedge clk);
		hold_rx <= 1'b0;
	end

	function automatic void add(kind_t k, longint unsigned p, logic [7:0] d,
		logic se, logic ls);
		seg_item_t it;
		it.kind = k;
		it.idx = p;
		it.data = d;
		it.seg_end = se;
		it.last = ls;
		to_send.push_back(it);
	endfunction

	task automatic wait_idle();
		wait (to_send.size() == 0);
		@(posedge clk);
		while (s_tvalid || status_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_window(int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[12:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		window_len = v;
	endtask

	// One batch of segments around the current drain point; end-of-stream
	// flags only go to positions far outside any window.
	task automatic random_batch(int n_items);
		longint unsigned base;
		longint unsigned start;
		int len;
		int order [$];
		int j;
		int w;
		base = drained_to;
		w = (window_len > RING) ? RING : window_len;
		while (to_send.size() < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 4))
				0: add(K_BYTE, {$urandom, $urandom}, 8'($urandom), 1'($urandom), 1'b0);
				1: add(K_NONE, {$urandom, $urandom}, 8'($urandom), 1'($urandom),
					1'($urandom));
				2: add(K_MARK, base + $urandom_range(0, 40), 8'($urandom), 1'($urandom),
					1'b0);
				3: add(K_BYTE, base + 64'd20000 + $urandom, 8'($urandom), 1'b1, 1'b1);
				default: add(K_MARK, base + 64'd20000 + $urandom, 8'($urandom), 1'b0,
					1'b1);
				endcase
			end else begin
				start = base + $urandom_range(0, w + 8);
				if ($urandom_range(0, 7) == 0 && base > 4)
					start = base - $urandom_range(1, 4);
				len = $urandom_range(1, 6);
				order.delete();
				for (j = 0; j < len; j++)
					order.push_back(j);
				if ($urandom_range(0, 2) == 0)
					order.shuffle();
				foreach (order[k])
					add(K_BYTE, start + order[k], 8'($urandom), order[k] == len - 1, 1'b0);
				base = base + $urandom_range(0, len);
				for (j = $urandom_range(0, len + 1); j > 0; j--)
					add(K_DRAIN, 0, 8'($urandom), 1'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		longint unsigned d;
		int k;
		int windows [9] = '{4096, 1, 8191, 0, 17, 300, 4095, 2, 64};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_mode = 0;
		hold_go = 0;
		mismatches = 0;
		results_seen = 0;
		bytes_out = 0;
		assembled_to = 0;
		drained_to = 0;
		stream_end = 0;
		end_seen = 0;
		is_closed = 0;
		pending_q = 0;
		window_len = 4096;
		foreach (held[i])
			held[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: in-order, out-of-order, duplicates, empty drains, window edges.
		add(K_BYTE, 0, 8'hFF, 1'b1, 1'b0);
		add(K_DRAIN, 0, 0, 0, 0);
		add(K_DRAIN, 0, 0, 0, 0);
		add(K_BYTE, 2, 8'h00, 1'b1, 1'b0);
		add(K_BYTE, 1, 8'hA5, 1'b0, 1'b0);
		add(K_BYTE, 1, 8'h5A, 1'b0, 1'b0);
		add(K_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b1);
		add(K_MARK, 5, 0, 1'b0, 1'b0);
		add(K_MARK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b1, 1'b1);
		add(K_BYTE, 8000, 8'h11, 1'b1, 1'b1);
		add(K_BYTE, 6, 8'h22, 1'b1, 1'b1 ^ 1'b1);
		add(K_BYTE, 7, 8'h33, 1'b0, 1'b1);
		add(K_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h44, 1'b1, 1'b0);
		add(K_DRAIN, 0, 0, 0, 0);
		add(K_DRAIN, 0, 0, 0, 0);
		add(K_BYTE, 4098, 8'h55, 1'b0, 1'b0);
		add(K_BYTE, 4099, 8'h66, 1'b0, 1'b0);
		add(K_BYTE, 3, 8'h77, 1'b0, 1'b0);
		add(K_DRAIN, 0, 0, 0, 0);
		add(K_DRAIN, 0, 0, 0, 0);
		wait_idle();

		for (k = 0; k < 9; k++) begin
			idle_mode = k % 3;
			write_window(windows[k]);
			if (k == 5)
				hold_go = 1;
			random_batch(120);
			wait_idle();
		end

		// End of stream: record an end, send bytes past it and fill the gap, which
		// closes the stream; later bytes and marks are ignored, then drains empty the window.
		write_window(4096);
		d = assembled_to;
		if ($urandom_range(0, 1))
			add(K_MARK, d + 20, 0, 1'b0, 1'b1);
		else
			add(K_BYTE, d + 19, 8'($urandom), 1'b1, 1'b1);
		add(K_MARK, d + 10, 0, 1'b0, 1'b1);
		add(K_BYTE, d + 21, 8'($urandom), 1'b0, 1'b0);
		add(K_BYTE, d + 25, 8'($urandom), 1'b1, 1'b0);
		for (k = 19; k >= 0; k--)
			add(K_BYTE, d + k, 8'($urandom), k == 19, 1'b0);
		for (k = 0; k < 8; k++) begin
			add(K_BYTE, d + 30 + k, 8'($urandom), 1'b0, 1'b0);
			add(K_MARK, d + k, 0, 1'b0, 1'b1);
		end
		for (k = 0; k < 40 + (assembled_to - drained_to); k++)
			add(K_DRAIN, 0, 0, 0, 0);
		wait_idle();
		repeat (50) @(posedge clk);

		$display("ran %0d results, %0d bytes drained, final window %0d, closed %0b",
			results_seen, bytes_out, window_len, is_closed);
		$display("mismatches: %0d, results still due: %0d", mismatches,
			status_due.size());
		if (mismatches == 0 && status_due.size() == 0)
			$display("stream_byte_reassembler_test: clean");
		else
			$display("stream_byte_reassembler_test: errors");
		$finish;
	end

endmodule
